/* hdl/assert_macros.svh */
// Assertion macros shared by the cluster bound RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define CGB_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/cgb_pkg.sv */
// Package for the cluster geometric bound block: widths, codes, constants.
// No dependencies; used by every module of the block.
`default_nettype none

package cgb_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int KIND_WIDTH      = 2;
   localparam int MIN_DIST_WIDTH  = 16;
   localparam int BOUND_WIDTH     = 48;
   // quotient of 2^48 / D needs 49 bits before saturation
   localparam int DIV_WIDTH       = BOUND_WIDTH + 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 3;

   localparam logic [MIN_DIST_WIDTH-1:0] MIN_DIST_RESET = MIN_DIST_WIDTH'(17);

   localparam logic [BOUND_WIDTH-1:0] BOUND_MAX = {BOUND_WIDTH{1'b1}};
   localparam logic [BOUND_WIDTH-1:0] ONE_Q24   = BOUND_WIDTH'(1) << 24;

   // light kinds
   localparam logic [KIND_WIDTH-1:0] KIND_OMNI        = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ORIENTED    = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_DIRECTIONAL = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_OTHER       = 2'd3;

   // register index, taken from word address bit
   localparam logic CSR_IDX_MIN_DIST = 1'b0;

   // one stage of the reciprocal pipeline
   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [DIV_WIDTH-1:0]  divisor;
      logic [DIV_WIDTH-1:0]  rem;
      logic [DIV_WIDTH-1:0]  quot;
   } cgb_dstage_type;

   // pipeline control handed from the top level
   typedef struct packed {
      logic en;
      logic valid;
   } cgb_ctrl_type;

endpackage

`default_nettype wire

/* hdl/cgb_dist.sv */
// Front end: clamp point into box, per axis square, sum and raise to minimum.
// Three register stages; depends on cgb_pkg.
`default_nettype none

module cgb_dist #(
   parameter int COORD_WIDTH = cgb_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cgb_pkg::cgb_ctrl_type                 ctrl,
   input  logic signed [COORD_WIDTH-1:0]         point_x,
   input  logic signed [COORD_WIDTH-1:0]         point_y,
   input  logic signed [COORD_WIDTH-1:0]         point_z,
   input  logic signed [COORD_WIDTH-1:0]         box_min_x,
   input  logic signed [COORD_WIDTH-1:0]         box_min_y,
   input  logic signed [COORD_WIDTH-1:0]         box_min_z,
   input  logic signed [COORD_WIDTH-1:0]         box_max_x,
   input  logic signed [COORD_WIDTH-1:0]         box_max_y,
   input  logic signed [COORD_WIDTH-1:0]         box_max_z,
   input  logic [cgb_pkg::KIND_WIDTH-1:0]        in_kind,
   input  logic [cgb_pkg::MIN_DIST_WIDTH-1:0]    min_dist_sq,
   output logic                                  out_valid,
   output logic [cgb_pkg::DIV_WIDTH-1:0]         out_divisor,
   output logic [cgb_pkg::KIND_WIDTH-1:0]        out_kind
);
   import cgb_pkg::*;

   localparam int SQ_WIDTH  = 2 * COORD_WIDTH;
   localparam int SUM_WIDTH = SQ_WIDTH + 2;
   localparam int CMP_WIDTH = (SUM_WIDTH > DIV_WIDTH + 1) ? SUM_WIDTH : DIV_WIDTH + 1;
   localparam logic [CMP_WIDTH-1:0] DIV_LIMIT = CMP_WIDTH'(1) << (DIV_WIDTH - 1);

   logic signed [COORD_WIDTH-1:0] pnt [3];
   logic signed [COORD_WIDTH-1:0] lo [3];
   logic signed [COORD_WIDTH-1:0] hi [3];
   logic signed [COORD_WIDTH-1:0] near_pt [3];
   logic signed [COORD_WIDTH:0]   diff [3];
   logic [COORD_WIDTH-1:0]        mag_in [3];
   logic [COORD_WIDTH-1:0]        mag_ff [3];
   logic [SQ_WIDTH-1:0]           sq_in [3];
   logic [SQ_WIDTH-1:0]           sq_ff [3];
   logic [CMP_WIDTH-1:0]          sum_ext;
   logic [CMP_WIDTH-1:0]          raised;
   logic [DIV_WIDTH-1:0]          div_in;
   logic [DIV_WIDTH-1:0]          div_ff;
   logic [2:0]                    vld_ff;
   logic [KIND_WIDTH-1:0]         kind1_ff;
   logic [KIND_WIDTH-1:0]         kind2_ff;
   logic [KIND_WIDTH-1:0]         kind3_ff;

   // stage 1: closest point and distance magnitude per axis
   always_comb begin
      pnt[0] = point_x;
      pnt[1] = point_y;
      pnt[2] = point_z;
      lo[0]  = box_min_x;
      lo[1]  = box_min_y;
      lo[2]  = box_min_z;
      hi[0]  = box_max_x;
      hi[1]  = box_max_y;
      hi[2]  = box_max_z;
      for (int a = 0; a < 3; a++) begin
         // lower bound is checked first; on an inverted box a point below it clamps to it, else to the upper bound
         if (pnt[a] < lo[a]) begin
            near_pt[a] = lo[a];
         end else if (pnt[a] > hi[a]) begin
            near_pt[a] = hi[a];
         end else begin
            near_pt[a] = pnt[a];
         end
         diff[a]   = (COORD_WIDTH+1)'(pnt[a]) - (COORD_WIDTH+1)'(near_pt[a]);
         mag_in[a] = diff[a][COORD_WIDTH] ? COORD_WIDTH'(-diff[a])
                                          : diff[a][COORD_WIDTH-1:0];
      end
   end

   // stage 2: squares
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = SQ_WIDTH'(mag_ff[a]) * SQ_WIDTH'(mag_ff[a]);
      end
   end

   // stage 3: sum, raise to minimum, clip to divisor width
   // anything above 2^48 gives a zero quotient, as does all ones
   always_comb begin
      sum_ext = CMP_WIDTH'(sq_ff[0]) + CMP_WIDTH'(sq_ff[1]) + CMP_WIDTH'(sq_ff[2]);
      raised  = (sum_ext < CMP_WIDTH'(min_dist_sq)) ? CMP_WIDTH'(min_dist_sq) : sum_ext;
      div_in  = (raised > DIV_LIMIT) ? {DIV_WIDTH{1'b1}} : raised[DIV_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctrl.en) begin
         vld_ff <= {vld_ff[1:0], ctrl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         mag_ff   <= mag_in;
         kind1_ff <= in_kind;
         sq_ff    <= sq_in;
         kind2_ff <= kind1_ff;
         div_ff   <= div_in;
         kind3_ff <= kind2_ff;
      end
   end

   assign out_valid   = vld_ff[2];
   assign out_divisor = div_ff;
   assign out_kind    = kind3_ff;

endmodule

`default_nettype wire

/* hdl/cgb_recip.sv */
// Reciprocal pipeline: floor(2^48 / D), one restoring quotient bit per stage.
// Depends on cgb_pkg.
`default_nettype none

module cgb_recip (
   input  logic                           clock,
   input  logic                           reset,
   input  cgb_pkg::cgb_ctrl_type          ctrl,
   input  logic [cgb_pkg::DIV_WIDTH-1:0]  in_divisor,
   input  logic [cgb_pkg::KIND_WIDTH-1:0] in_kind,
   output logic                           out_valid,
   output logic [cgb_pkg::DIV_WIDTH-1:0]  out_quot,
   output logic [cgb_pkg::KIND_WIDTH-1:0] out_kind
);
   import cgb_pkg::*;

   localparam int STAGES = DIV_WIDTH;

   cgb_dstage_type       src [STAGES];
   cgb_dstage_type       nxt [STAGES];
   cgb_dstage_type       data_ff [STAGES];
   logic [STAGES-1:0]    vld_ff;
   logic [DIV_WIDTH:0]   r_shift [STAGES];
   logic [DIV_WIDTH:0]   r_diff [STAGES];
   logic [STAGES-1:0]    ge;

   always_comb begin
      src[0].kind    = in_kind;
      src[0].divisor = in_divisor;
      src[0].rem     = '0;
      src[0].quot    = '0;
      for (int k = 1; k < STAGES; k++) begin
         src[k] = data_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         // dividend is 2^48: only the first stage shifts in a one
         r_shift[k] = {src[k].rem, (k == 0)};
         r_diff[k]  = r_shift[k] - {1'b0, src[k].divisor};
         ge[k]      = r_shift[k] >= {1'b0, src[k].divisor};
         nxt[k].kind    = src[k].kind;
         nxt[k].divisor = src[k].divisor;
         nxt[k].rem     = ge[k] ? r_diff[k][DIV_WIDTH-1:0] : r_shift[k][DIV_WIDTH-1:0];
         nxt[k].quot    = {src[k].quot[DIV_WIDTH-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctrl.en) begin
         vld_ff <= {vld_ff[STAGES-2:0], ctrl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         data_ff <= nxt;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_quot  = data_ff[STAGES-1].quot;
   assign out_kind  = data_ff[STAGES-1].kind;

endmodule

`default_nettype wire

/* hdl/cluster_geometric_bound.sv */
// Cluster geometric bound: an accepted item passes 3 distance stages, 49 reciprocal
// stages of one quotient bit each and 1 output stage before its result is valid.
// Throughput one item per cycle; the whole pipeline stalls while a result waits.
// Synchronous active-high reset clears valid bits and sets min_dist_sq to 17.
// Depends on cgb_pkg, cgb_dist, cgb_recip and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cluster_geometric_bound #(
   parameter int COORD_WIDTH = cgb_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [COORD_WIDTH-1:0]        req_point_x,
   input  logic signed [COORD_WIDTH-1:0]        req_point_y,
   input  logic signed [COORD_WIDTH-1:0]        req_point_z,
   input  logic signed [COORD_WIDTH-1:0]        req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0]        req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0]        req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0]        req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0]        req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0]        req_box_max_z,
   input  logic [cgb_pkg::KIND_WIDTH-1:0]       req_light_kind,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cgb_pkg::BOUND_WIDTH-1:0]      rsp_bound,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cgb_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [cgb_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [cgb_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import cgb_pkg::*;

   cgb_ctrl_type            ctrl_in;
   cgb_ctrl_type            ctrl_mid;
   logic                    en;
   logic                    csr_wr;
   logic [MIN_DIST_WIDTH-1:0] min_dist_ff;
   logic                    dist_valid;
   logic [DIV_WIDTH-1:0]    dist_divisor;
   logic [KIND_WIDTH-1:0]   dist_kind;
   logic                    recip_valid;
   logic [DIV_WIDTH-1:0]    recip_quot;
   logic [KIND_WIDTH-1:0]   recip_kind;
   logic [BOUND_WIDTH-1:0]  sat_quot;
   logic [BOUND_WIDTH-1:0]  bound_in;
   logic [BOUND_WIDTH-1:0]  bound_ff;
   logic [KIND_WIDTH-1:0]   kind_ff;
   logic                    rsp_valid_ff;

   // whole pipeline moves unless a finished item is held at the output
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   assign ctrl_in.en     = en;
   assign ctrl_in.valid  = req_valid;
   assign ctrl_mid.en    = en;
   assign ctrl_mid.valid = dist_valid;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MIN_DIST) ? CSR_DATA_WIDTH'(min_dist_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MIN_DIST_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_MIN_DIST)) begin
         min_dist_ff <= csr_pwdata[MIN_DIST_WIDTH-1:0];
      end
   end

   cgb_dist #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl_in),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .point_z     (req_point_z),
      .box_min_x   (req_box_min_x),
      .box_min_y   (req_box_min_y),
      .box_min_z   (req_box_min_z),
      .box_max_x   (req_box_max_x),
      .box_max_y   (req_box_max_y),
      .box_max_z   (req_box_max_z),
      .in_kind     (req_light_kind),
      .min_dist_sq (min_dist_ff),
      .out_valid   (dist_valid),
      .out_divisor (dist_divisor),
      .out_kind    (dist_kind)
   );

   cgb_recip u_recip (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_mid),
      .in_divisor (dist_divisor),
      .in_kind    (dist_kind),
      .out_valid  (recip_valid),
      .out_quot   (recip_quot),
      .out_kind   (recip_kind)
   );

   // divisor of 0 or 1 gives a quotient of 2^48 or more
   assign sat_quot = (recip_quot > DIV_WIDTH'(BOUND_MAX)) ? BOUND_MAX
                                                         : recip_quot[BOUND_WIDTH-1:0];

   always_comb begin
      case (recip_kind) inside
         KIND_OMNI, KIND_ORIENTED: bound_in = sat_quot;
         KIND_DIRECTIONAL:         bound_in = ONE_Q24;
         default:                  bound_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= recip_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bound_ff <= bound_in;
         kind_ff  <= recip_kind;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bound = bound_ff;

   `CGB_ASSERT_ALWAYS(a_min_reset, clock, $fell(reset) |-> (min_dist_ff == MIN_DIST_RESET), "min_dist_sq not at reset value")
   `CGB_ASSERT_CLK(a_min_write, clock, reset, (csr_wr && (csr_paddr[2] == CSR_IDX_MIN_DIST)) |=> (min_dist_ff == $past(csr_pwdata[MIN_DIST_WIDTH-1:0])), "min_dist_sq write lost")
   `CGB_ASSERT_CLK(a_kind_const, clock, reset, (rsp_valid && (kind_ff == KIND_DIRECTIONAL)) |-> (rsp_bound == ONE_Q24), "directional bound is not one")

endmodule

`default_nettype wire
